// ----- rtl/core/sacf_pkg.sv -----
// Package for the set-associative cache lookup with FIFO replacement.
// Holds field widths, register indexes, reset values and the controller states.
// No dependencies.
package sacf_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_MAX_WAYS    = 8;

    localparam int ADDR_W     = 31;
    localparam int TOTAL_W    = 11;
    localparam int WAYS_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS          = 1'b1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd64;
    localparam logic [WAYS_W-1:0]  WAYS_RESET  = 4'd1;

    typedef enum logic [7:0] {
        ST_CLEAR    = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_DIV_SETS = 8'b0000_0100,
        ST_DIV_ADDR = 8'b0000_1000,
        ST_BASE     = 8'b0001_0000,
        ST_SEARCH   = 8'b0010_0000,
        ST_MISS     = 8'b0100_0000,
        ST_RESULT   = 8'b1000_0000
    } state_t;

endpackage

// ----- rtl/core/set_assoc_cache_fifo_lookup.sv -----
// Set-associative cache lookup with FIFO replacement per set.
// Depends on sacf_pkg. Line store and pointer store are internal synchronous memories.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata: address[30:0], zero pad
// m_*       out  m_tvalid/m_tready   m_tdata: hit[0], zero pad
// cfg_*     in   cfg_we              cfg_index, cfg_data (total_entries, ways)
//
// For each address a shared one-bit-a-cycle divider first forms the set count (11 steps),
// then splits the address into tag and set (31 steps), then the ways are read one a cycle
// from the single line memory port. After reset the block sweeps every entry of both
// memories with s_tready low. A result waiting in the output register does not stop the
// next address from being taken; only its final handoff waits on m_tready.
module set_assoc_cache_fifo_lookup #(
    parameter int MAX_ENTRIES = sacf_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_WAYS    = sacf_pkg::DEF_MAX_WAYS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sacf_pkg::S_TDATA_W-1:0]   s_tdata,   // [30:0] address, [31] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sacf_pkg::M_TDATA_W-1:0]   m_tdata    // [0] hit, [7:1] zero
);
    import sacf_pkg::*;

    localparam int DEPTH = MAX_ENTRIES + MAX_WAYS;
    localparam int LW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = $clog2(MAX_ENTRIES + 1);
    localparam int WW    = $clog2(MAX_WAYS + 1);
    localparam int DVW   = (EW > WW) ? EW : WW;
    localparam int PW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SIW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(ADDR_W + 1);

    // configuration
    logic [TOTAL_W-1:0] total_reg;
    logic [WAYS_W-1:0]  ways_reg;
    logic [EW-1:0]      eff_entries;
    logic [WW-1:0]      eff_ways;

    // control
    state_t          state_reg, state_next;
    logic [LW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [WW-1:0]   rd_way_reg, rd_way_next;
    logic [WW-1:0]   chk_way_reg, chk_way_next;
    logic            chk_vld_reg, chk_vld_next;
    logic            m_valid_reg, m_valid_next;

    // payload
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] tag_reg, tag_next;
    logic [DVW-1:0]    set_reg, set_next;
    logic [WW-1:0]     w_reg, w_next;
    logic [LW-1:0]     base_reg, base_next;
    logic              hit_reg, hit_next;
    logic              hit_out_reg, hit_out_next;

    // shared restoring divider
    logic [ADDR_W-1:0] div_q_reg, div_q_next;
    logic [DVW-1:0]    div_r_reg, div_r_next;
    logic [DVW-1:0]    div_d_reg, div_d_next;
    logic [CW-1:0]     div_cnt_reg, div_cnt_next;
    logic [DVW:0]      div_shift;
    logic [DVW:0]      div_diff;
    logic [ADDR_W-1:0] div_q_step;
    logic [DVW-1:0]    div_r_step;
    logic [DVW-1:0]    sets_quot;

    // memories
    logic [ADDR_W:0]   line_mem [DEPTH];
    logic [PW-1:0]     ptr_mem  [MAX_ENTRIES];
    logic              line_re, line_we;
    logic [LW-1:0]     line_raddr, line_waddr;
    logic [ADDR_W:0]   line_wdata, line_q;
    logic              ptr_re, ptr_we;
    logic [SIW-1:0]    ptr_raddr, ptr_waddr;
    logic [PW-1:0]     ptr_wdata, ptr_q;

    // replacement pointer arithmetic
    logic [WW-1:0]     ptr_ext, ptr_eff, ptr_inc;
    logic [DVW+WW-1:0] base_prod;

    always_comb
    begin
        if (ways_reg == '0)
            eff_ways = WW'(1);
        else if (32'(ways_reg) > MAX_WAYS)
            eff_ways = WW'(MAX_WAYS);
        else
            eff_ways = WW'(ways_reg);

        if (total_reg == '0)
            eff_entries = EW'(1);
        else if (32'(total_reg) > MAX_ENTRIES)
            eff_entries = EW'(MAX_ENTRIES);
        else
            eff_entries = EW'(total_reg);
    end

    // one quotient bit per cycle
    always_comb
    begin
        div_shift  = {div_r_reg, div_q_reg[ADDR_W-1]};
        div_diff   = div_shift - {1'b0, div_d_reg};
        div_q_step = {div_q_reg[ADDR_W-2:0], ~div_diff[DVW]};
        div_r_step = div_diff[DVW] ? div_shift[DVW-1:0] : div_diff[DVW-1:0];
        sets_quot  = (div_q_reg[DVW-1:0] == '0) ? DVW'(1) : div_q_reg[DVW-1:0];
    end

    assign base_prod = set_reg * w_reg;

    always_comb
    begin
        ptr_ext = WW'(ptr_q);
        ptr_eff = (ptr_ext >= w_reg) ? '0 : ptr_ext;
        ptr_inc = ptr_eff + WW'(1);
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        rd_way_next   = rd_way_reg;
        chk_way_next  = rd_way_reg;
        chk_vld_next  = 1'b0;
        m_valid_next  = m_valid_reg;
        addr_next     = addr_reg;
        tag_next      = tag_reg;
        set_next      = set_reg;
        w_next        = w_reg;
        base_next     = base_reg;
        hit_next      = hit_reg;
        hit_out_next  = hit_out_reg;
        div_q_next    = div_q_reg;
        div_r_next    = div_r_reg;
        div_d_next    = div_d_reg;
        div_cnt_next  = div_cnt_reg;

        s_tready   = 1'b0;
        line_re    = 1'b0;
        line_we    = 1'b0;
        line_raddr = base_reg + LW'(rd_way_reg);
        line_waddr = base_reg + LW'(ptr_eff);
        line_wdata = {1'b1, tag_reg};
        ptr_re     = 1'b0;
        ptr_we     = 1'b0;
        ptr_raddr  = set_reg[SIW-1:0];
        ptr_waddr  = set_reg[SIW-1:0];
        ptr_wdata  = (ptr_inc >= w_reg) ? '0 : PW'(ptr_inc);

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                line_we    = 1'b1;
                line_waddr = clr_cnt_reg;
                line_wdata = '0;
                ptr_we     = (clr_cnt_reg < LW'(MAX_ENTRIES));
                ptr_waddr  = clr_cnt_reg[SIW-1:0];
                ptr_wdata  = '0;
                if (clr_cnt_reg == LW'(DEPTH - 1))
                    state_next = ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + LW'(1);
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    addr_next    = s_tdata[ADDR_W-1:0];
                    w_next       = eff_ways;
                    div_q_next   = ADDR_W'(eff_entries) << (ADDR_W - EW);
                    div_r_next   = '0;
                    div_d_next   = DVW'(eff_ways);
                    div_cnt_next = CW'(EW);
                    state_next   = ST_DIV_SETS;
                end
            end
            ST_DIV_SETS:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_q_next   = div_q_step;
                    div_r_next   = div_r_step;
                    div_cnt_next = div_cnt_reg - CW'(1);
                end
                else
                begin
                    // set count known: divide the address by it
                    div_q_next   = addr_reg;
                    div_r_next   = '0;
                    div_d_next   = sets_quot;
                    div_cnt_next = CW'(ADDR_W);
                    state_next   = ST_DIV_ADDR;
                end
            end
            ST_DIV_ADDR:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_q_next   = div_q_step;
                    div_r_next   = div_r_step;
                    div_cnt_next = div_cnt_reg - CW'(1);
                end
                else
                begin
                    tag_next   = div_q_reg;
                    set_next   = div_r_reg;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                base_next   = LW'(base_prod);
                ptr_re      = 1'b1;
                rd_way_next = '0;
                state_next  = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                // issue one way per cycle, check the previous one
                if (rd_way_reg < w_reg)
                begin
                    line_re      = 1'b1;
                    chk_vld_next = 1'b1;
                    rd_way_next  = rd_way_reg + WW'(1);
                end
                if (chk_vld_reg)
                begin
                    if (line_q[ADDR_W] && (line_q[ADDR_W-1:0] == tag_reg))
                    begin
                        hit_next     = 1'b1;
                        chk_vld_next = 1'b0;
                        state_next   = ST_RESULT;
                    end
                    else if (chk_way_reg == w_reg - WW'(1))
                    begin
                        hit_next     = 1'b0;
                        chk_vld_next = 1'b0;
                        state_next   = ST_MISS;
                    end
                end
            end
            ST_MISS:
            begin
                line_we    = 1'b1;
                ptr_we     = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    hit_out_next = hit_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_way_reg  <= '0;
            chk_way_reg <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            div_cnt_reg <= '0;
            total_reg   <= TOTAL_RESET;
            ways_reg    <= WAYS_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_way_reg  <= rd_way_next;
            chk_way_reg <= chk_way_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
            div_cnt_reg <= div_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOTAL_ENTRIES: total_reg <= cfg_data[TOTAL_W-1:0];
                    REG_WAYS:          ways_reg  <= cfg_data[WAYS_W-1:0];
                    default:           total_reg <= total_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        tag_reg     <= tag_next;
        set_reg     <= set_next;
        w_reg       <= w_next;
        base_reg    <= base_next;
        hit_reg     <= hit_next;
        hit_out_reg <= hit_out_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_d_reg   <= div_d_next;
    end

    // line store: valid bit above the tag
    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[line_waddr] <= line_wdata;
        if (line_re)
            line_q <= line_mem[line_raddr];
    end

    // FIFO replacement pointer per set
    always_ff @(posedge clk)
    begin
        if (ptr_we)
            ptr_mem[ptr_waddr] <= ptr_wdata;
        if (ptr_re)
            ptr_q <= ptr_mem[ptr_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, hit_out_reg};

endmodule

// ----- sim/sacf_lookup_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the set-associative cache lookup: it mirrors the line store and the FIFO
// pointers, predicts hit or miss per address and compares each result in order.
// Depends on sacf_pkg for widths, register indexes and reset values.
module sacf_lookup_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [sacf_pkg::S_TDATA_W-1:0]   s_tdata,   // [30:0] address, [31] zero
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sacf_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] hit, [7:1] zero
    output int                               errors,
    output int unsigned                      pending
);

    import sacf_pkg::*;

    localparam int unsigned LINE_DEPTH = DEF_MAX_ENTRIES + DEF_MAX_WAYS;
    localparam int unsigned EXP_DEPTH  = 16;

    typedef struct packed {
        logic                hit;
        logic [ADDR_W-1:0]   address;
    } lookup_t;

    logic [TOTAL_W-1:0] total_cfg;
    logic [WAYS_W-1:0]  ways_cfg;

    bit                 line_valid [LINE_DEPTH];
    logic [ADDR_W-1:0]  line_tag   [LINE_DEPTH];
    logic [2:0]         fifo_ptr   [LINE_DEPTH];

    // expected results in order, kept in a small ring
    lookup_t            exp_buf [EXP_DEPTH];
    int unsigned        exp_wr;
    int unsigned        exp_rd;
    int unsigned        exp_count;
    lookup_t            oldest;

    // Search the set for the tag; on a miss fill the way the set's FIFO pointer names.
    function automatic bit probe_and_fill(input logic [ADDR_W-1:0] address);
        int unsigned nways, entries, sets, set_idx, tag, base, way, ptr;
        bit          found;
        nways   = (ways_cfg == 0) ? 1 : ((ways_cfg > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_cfg);
        entries = (total_cfg == 0) ? 1
                : ((total_cfg > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : total_cfg);
        sets    = entries / nways;
        if (sets == 0)
            sets = 1;
        set_idx = address % sets;
        tag     = address / sets;
        base    = set_idx * nways;
        found   = 1'b0;
        for (way = 0; way < nways; way++)
        begin
            if (base + way < LINE_DEPTH && line_valid[base + way]
                && {1'b0, line_tag[base + way]} == tag)
                found = 1'b1;
        end
        if (!found && set_idx < LINE_DEPTH)
        begin
            ptr = fifo_ptr[set_idx];
            // a pointer left over from a wider layout restarts at way 0
            if (ptr >= nways)
                ptr = 0;
            if (base + ptr < LINE_DEPTH)
            begin
                line_tag[base + ptr]   = tag[ADDR_W-1:0];
                line_valid[base + ptr] = 1'b1;
            end
            ptr = ptr + 1;
            if (ptr >= nways)
                ptr = 0;
            fifo_ptr[set_idx] = ptr[2:0];
        end
        return found;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_cfg = TOTAL_RESET;
            ways_cfg  = WAYS_RESET;
            for (int k = 0; k < LINE_DEPTH; k++)
            begin
                line_valid[k] = 1'b0;
                fifo_ptr[k]   = 3'd0;
            end
            exp_wr    = 0;
            exp_rd    = 0;
            exp_count = 0;
            pending   = 0;
            errors    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOTAL_ENTRIES: total_cfg = cfg_data[TOTAL_W-1:0];
                    REG_WAYS:          ways_cfg  = cfg_data[WAYS_W-1:0];
                    default:           ;
                endcase
            end
            // retire results before taking new addresses in the same cycle
            if (m_tvalid && m_tready)
            begin
                if (exp_count == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result transaction with nothing expected, hit %0d",
                                 $realtime, m_tdata[0]);
                    errors++;
                end
                else
                begin
                    oldest    = exp_buf[exp_rd];
                    exp_rd    = (exp_rd + 1) % EXP_DEPTH;
                    exp_count = exp_count - 1;
                    if (m_tdata[0] !== oldest.hit)
                    begin
                        if (errors < 10)
                            $display("%0t: address 0x%08h: hit expected %0d, got %0b",
                                     $realtime, oldest.address, oldest.hit, m_tdata[0]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (exp_count == EXP_DEPTH)
                begin
                    if (errors < 10)
                        $display("%0t: too many transactions in flight", $realtime);
                    errors++;
                end
                else
                begin
                    exp_buf[exp_wr] = {probe_and_fill(s_tdata[ADDR_W-1:0]),
                                       s_tdata[ADDR_W-1:0]};
                    exp_wr          = (exp_wr + 1) % EXP_DEPTH;
                    exp_count       = exp_count + 1;
                end
            end
            pending = exp_count;
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Top of the cache lookup regression: clock, reset, config writes, address stimulus and
// output backpressure. Depends on sacf_pkg, set_assoc_cache_fifo_lookup and sacf_lookup_checker.
module tb;

    import sacf_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // [30:0] address, [31] zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // [0] hit, [7:1] zero

    int                     errors;
    int unsigned            pending;
    logic                   s_accepted;
    int unsigned            burst_left;
    int unsigned            gap_max;
    logic [ADDR_W-1:0]      hot_addrs [24];

    set_assoc_cache_fifo_lookup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sacf_lookup_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // capture the input handshake at the edge so the sender can act on it at the falling edge
    always @(posedge clk)
        s_accepted <= s_tvalid && s_tready;

    // Send one address; start a new burst after a random gap when the current one runs out.
    task automatic send_item(input logic [ADDR_W-1:0] address);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, address};
        do @(negedge clk); while (!s_accepted);
    endtask

    // Hold off the sender until every outstanding lookup has returned.
    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_config(input logic [TOTAL_W-1:0] total, input logic [WAYS_W-1:0] nways);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TOTAL_ENTRIES;
        cfg_data  <= total;
        @(negedge clk);
        cfg_index <= REG_WAYS;
        cfg_data  <= {{(CFG_DATA_W-WAYS_W){1'b0}}, nways};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // output backpressure: stretches of always-ready, random and periodic stalls
    initial
    begin
        int unsigned mode, stretch, period, duty, tick;
        m_tready = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 400);
            period  = $urandom_range(2, 40);
            duty    = $urandom_range(1, period - 1);
            tick    = 0;
            repeat (stretch)
            begin
                @(negedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % period) < duty);
                endcase
                tick++;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("set_assoc_cache_fifo_lookup regression: fail");
        $finish;
    end

    initial
    begin
        logic [TOTAL_W-1:0] total;
        logic [WAYS_W-1:0]  nways;
        logic [ADDR_W-1:0]  address;
        int unsigned        entries, eff_ways, sets, hot_a, hot_b, n_hot, count, pick;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_TOTAL_ENTRIES;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        burst_left = 0;
        gap_max    = 6;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset layout, 64 sets of one way: hit, conflict eviction, top address
        send_item(31'd0);
        send_item(31'd0);
        send_item(31'd64);
        send_item(31'd0);
        send_item(31'h7FFF_FFFF);
        send_item(31'h7FFF_FFFF);
        send_item(31'd63);

        // zero entries and zero ways fall back to a single line
        wait_drained();
        write_config(11'd0, 4'd0);
        send_item(31'd5);
        send_item(31'd5);
        send_item(31'd6);

        // oversized registers saturate to 128 sets of 8: fill set 1, evict its oldest line
        wait_drained();
        write_config(11'd2047, 4'd15);
        for (int k = 0; k < 9; k++)
            send_item(31'(1 + 128 * k));
        send_item(31'd129);

        // fewer entries than ways: one set of 8; the old line holding tag 6 hits again
        wait_drained();
        write_config(11'd3, 4'd8);
        send_item(31'd6);
        send_item(31'd7);
        send_item(31'd8);
        send_item(31'd9);

        // narrow the ways so set 0's pointer is out of range, then hit a reinterpreted line
        wait_drained();
        write_config(11'd4, 4'd2);
        send_item(31'd0);
        send_item(31'd16);

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: begin total = 11'd1024; nways = 4'd8;  end
                1: begin total = 11'd1;    nways = 4'd1;  end
                2: begin total = 11'd2047; nways = 4'd15; end
                3: begin total = 11'd0;    nways = 4'd0;  end
                4: begin total = 11'd1024; nways = 4'd1;  end
                5: begin total = 11'd1;    nways = 4'd8;  end
                default:
                begin
                    total = 11'($urandom_range(0, 2047));
                    nways = 4'($urandom_range(0, 15));
                end
            endcase
            wait_drained();
            write_config(total, nways);
            gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 16);

            // build a working set packed into two sets so lines get reused and evicted
            eff_ways = (nways == 0) ? 1 : ((nways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : nways);
            entries  = (total == 0) ? 1
                     : ((total > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : total);
            sets     = entries / eff_ways;
            if (sets == 0)
                sets = 1;
            hot_a = $urandom_range(0, sets - 1);
            hot_b = $urandom_range(0, sets - 1);
            n_hot = $urandom_range(4, 24);
            for (int i = 0; i < n_hot; i++)
                hot_addrs[i] = 31'(((i % 2) ? hot_a : hot_b) + sets *
                               (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40)));

            count = $urandom_range(120, 150);
            repeat (count)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    address = hot_addrs[$urandom_range(0, n_hot - 1)];
                else if (pick < 85)
                    address = hot_addrs[$urandom_range(0, n_hot - 1)]
                              ^ (31'd1 << $urandom_range(0, 30));
                else
                    address = 31'($urandom);
                send_item(address);
            end
        end

        wait_drained();
        repeat (80) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("set_assoc_cache_fifo_lookup regression: pass");
        else
            $display("set_assoc_cache_fifo_lookup regression: fail");
        $finish;
    end

endmodule
